// File: rtl/core/ect_pkg.sv
// Shared types, constants and month tables for the epoch-to-calendar pipeline.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package ect_pkg;

   localparam int ZONE_W     = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] CSR_IDX_ZONE = 1'b0;

   localparam logic [32:0] LAST_VALID_SECOND = 33'd4102444799;
   localparam logic [16:0] DAY_BIAS          = 17'd25568;
   localparam logic [11:0] BASE_YEAR         = 12'd1900;
   localparam logic [9:0]  YEAR_LAST_DAY     = 10'd364;

   localparam logic [39:0] RECIP_TEN      = 40'd838861;
   localparam logic [50:0] RECIP_DAY      = 51'd50903317;
   localparam logic [25:0] DAY_SHIFTED    = 26'd675;
   localparam logic [33:0] RECIP_CYCLE    = 34'd91868;
   localparam logic [33:0] RECIP_YEAR     = 34'd183860;
   localparam logic [16:0] YEAR_DAYS      = 17'd365;
   localparam logic [33:0] RECIP_SIXTY    = 34'd139811;
   localparam logic [21:0] RECIP_SIXTY_SM = 22'd1093;

   localparam int DATE_DEPTH  = 7;
   localparam int CLOCK_DEPTH = 3;

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [16:0] frac;
      logic [16:0] day_id;
      logic [16:0] day_sec;
   } split_type;

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [16:0] frac;
   } side_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } clock_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
      logic [8:0] base;
      base = 9'd0;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// File: rtl/core/ect_split.sv
// Front pipeline: zone adjustment, range check, day count, second of day and fraction.
// Three register stages; depends on ect_pkg.
`timescale 1ns / 1ps

module ect_split (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [31:0]                 epoch_seconds,
   input  logic [19:0]                 micro_part,
   input  logic                        parse_failed,
   input  logic [ect_pkg::ZONE_W-1:0]  zone_offset,
   output ect_pkg::split_type          split_out
);

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [24:0] upper;
      logic [6:0]  lower;
      logic [16:0] frac;
   } s1_type;

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [15:0] days;
      logic [24:0] upper;
      logic [6:0]  lower;
      logic [16:0] frac;
   } s2_type;

   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   ect_pkg::split_type s3_ff, s3_in;

   logic [33:0] adjusted;
   logic [39:0] frac_prod;
   logic [50:0] day_prod;
   logic [25:0] day_back;
   logic [25:0] day_rest;

   always_comb begin
      adjusted  = {2'b00, epoch_seconds}
                - {{(34 - ect_pkg::ZONE_W){zone_offset[ect_pkg::ZONE_W-1]}}, zone_offset};
      frac_prod = {20'd0, micro_part} * ect_pkg::RECIP_TEN;
      s1_in.valid = in_valid;
      s1_in.ok    = !parse_failed && !adjusted[33]
                 && (adjusted[32:0] <= ect_pkg::LAST_VALID_SECOND);
      s1_in.upper = adjusted[31:7];
      s1_in.lower = adjusted[6:0];
      s1_in.frac  = frac_prod[39:23];
   end

   always_comb begin
      day_prod    = {26'd0, s1_ff.upper} * ect_pkg::RECIP_DAY;
      s2_in.valid = s1_ff.valid;
      s2_in.ok    = s1_ff.ok;
      s2_in.days  = day_prod[50:35];
      s2_in.upper = s1_ff.upper;
      s2_in.lower = s1_ff.lower;
      s2_in.frac  = s1_ff.frac;
   end

   always_comb begin
      day_back      = {10'd0, s2_ff.days} * ect_pkg::DAY_SHIFTED;
      day_rest      = {1'b0, s2_ff.upper} - day_back;
      s3_in.valid   = s2_ff.valid;
      s3_in.ok      = s2_ff.ok;
      s3_in.frac    = s2_ff.frac;
      s3_in.day_id  = {1'b0, s2_ff.days} + ect_pkg::DAY_BIAS;
      s3_in.day_sec = {day_rest[9:0], s2_ff.lower};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign split_out = s3_ff;

endmodule

// File: rtl/core/ect_date.sv
// Date pipeline: year from the 1461-day cycle, month and day from cumulative tables.
// Seven register stages; depends on ect_pkg.
`timescale 1ns / 1ps

module ect_date (
   input  logic              clock,
   input  logic              adv,
   input  logic [16:0]       day_id,
   output ect_pkg::date_type date_out
);

   typedef struct packed {
      logic [16:0] id;
      logic [6:0]  cycles;
   } d1_type;

   typedef struct packed {
      logic [16:0] id;
      logic [16:0] adj;
   } d2_type;

   typedef struct packed {
      logic [16:0] id;
      logic [16:0] adj;
      logic [7:0]  yr;
   } d3_type;

   typedef struct packed {
      logic [16:0] id;
      logic [16:0] adj;
      logic [7:0]  yr;
      logic [16:0] yr_days;
   } d4_type;

   typedef struct packed {
      logic [7:0] yr;
      logic [9:0] ydays;
      logic       adj_whole;
   } d5_type;

   typedef struct packed {
      logic [7:0] yr;
      logic [9:0] ydays;
      logic       wrap;
      logic       leap;
      logic [3:0] idx;
   } d6_type;

   d1_type            d1_ff, d1_in;
   d2_type            d2_ff, d2_in;
   d3_type            d3_ff, d3_in;
   d4_type            d4_ff, d4_in;
   d5_type            d5_ff, d5_in;
   d6_type            d6_ff, d6_in;
   ect_pkg::date_type d7_ff, d7_in;

   logic [33:0] cycle_prod;
   logic [33:0] year_prod;
   logic [7:0]  yr_less;
   logic [16:0] ydays_full;
   logic [9:0]  day_full;

   always_comb begin
      cycle_prod   = {17'd0, day_id} * ect_pkg::RECIP_CYCLE;
      d1_in.id     = day_id;
      d1_in.cycles = cycle_prod[33:27];

      d2_in.id  = d1_ff.id;
      d2_in.adj = d1_ff.id - {10'd0, d1_ff.cycles};

      year_prod = {17'd0, d2_ff.adj} * ect_pkg::RECIP_YEAR;
      d3_in.id  = d2_ff.id;
      d3_in.adj = d2_ff.adj;
      d3_in.yr  = year_prod[33:26];

      d4_in.id      = d3_ff.id;
      d4_in.adj     = d3_ff.adj;
      d4_in.yr      = d3_ff.yr;
      d4_in.yr_days = {9'd0, d3_ff.yr} * ect_pkg::YEAR_DAYS;

      yr_less         = d4_ff.yr - 8'd1;
      ydays_full      = d4_ff.id - {11'd0, yr_less[7:2]} - d4_ff.yr_days;
      d5_in.yr        = d4_ff.yr;
      d5_in.ydays     = ydays_full[9:0];
      d5_in.adj_whole = (d4_ff.adj == d4_ff.yr_days);

      d6_in.yr    = d5_ff.yr;
      d6_in.ydays = d5_ff.ydays;
      d6_in.wrap  = d5_ff.adj_whole
                 && ((d5_ff.ydays == 10'd0) || (d5_ff.ydays > ect_pkg::YEAR_LAST_DAY));
      d6_in.leap  = (d5_ff.yr[1:0] == 2'b00);
      d6_in.idx   = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (d5_ff.ydays > {1'b0, ect_pkg::cum_days(d6_in.leap, 4'(i))}) begin
            d6_in.idx = 4'(i);
         end
      end

      day_full = d6_ff.ydays - {1'b0, ect_pkg::cum_days(d6_ff.leap, d6_ff.idx)};
      if (d6_ff.wrap) begin
         d7_in.year  = ect_pkg::BASE_YEAR + {4'd0, d6_ff.yr} - 12'd1;
         d7_in.month = 4'd12;
         d7_in.day   = 5'd31;
      end else begin
         d7_in.year  = ect_pkg::BASE_YEAR + {4'd0, d6_ff.yr};
         d7_in.month = d6_ff.idx + 4'd1;
         d7_in.day   = day_full[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         d3_ff <= d3_in;
         d4_ff <= d4_in;
         d5_ff <= d5_in;
         d6_ff <= d6_in;
         d7_ff <= d7_in;
      end
   end

   assign date_out = d7_ff;

endmodule

// File: rtl/core/ect_clock.sv
// Time-of-day pipeline: hour, minute and second from the second of the day.
// Three working stages padded to the date pipeline depth; depends on ect_pkg.
`timescale 1ns / 1ps

module ect_clock (
   input  logic               clock,
   input  logic               adv,
   input  logic [16:0]        day_sec,
   output ect_pkg::clock_type clock_out
);

   localparam int PAD = ect_pkg::DATE_DEPTH - ect_pkg::CLOCK_DEPTH;

   typedef struct packed {
      logic [16:0] day_sec;
      logic [10:0] minutes;
   } c1_type;

   typedef struct packed {
      logic [10:0] minutes;
      logic [4:0]  hour;
      logic [5:0]  second;
   } c2_type;

   c1_type             c1_ff, c1_in;
   c2_type             c2_ff, c2_in;
   ect_pkg::clock_type c3_ff, c3_in;
   ect_pkg::clock_type pad_ff [PAD];

   logic [33:0] min_prod;
   logic [16:0] min_back;
   logic [16:0] sec_full;
   logic [21:0] hour_prod;
   logic [10:0] hour_back;
   logic [10:0] min_full;

   always_comb begin
      min_prod      = {17'd0, day_sec} * ect_pkg::RECIP_SIXTY;
      c1_in.day_sec = day_sec;
      c1_in.minutes = min_prod[33:23];

      min_back      = {6'd0, c1_ff.minutes} * 17'd60;
      sec_full      = c1_ff.day_sec - min_back;
      hour_prod     = {11'd0, c1_ff.minutes} * ect_pkg::RECIP_SIXTY_SM;
      c2_in.minutes = c1_ff.minutes;
      c2_in.hour    = hour_prod[20:16];
      c2_in.second  = sec_full[5:0];

      hour_back    = {6'd0, c2_ff.hour} * 11'd60;
      min_full     = c2_ff.minutes - hour_back;
      c3_in.hour   = c2_ff.hour;
      c3_in.minute = min_full[5:0];
      c3_in.second = c2_ff.second;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff     <= c1_in;
         c2_ff     <= c2_in;
         c3_ff     <= c3_in;
         pad_ff[0] <= c3_ff;
         for (int i = 1; i < PAD; i++) begin
            pad_ff[i] <= pad_ff[i-1];
         end
      end
   end

   assign clock_out = pad_ff[PAD-1];

endmodule

// File: rtl/core/epoch_seconds_to_calendar_top.sv
// Top level of the epoch-to-calendar converter: configuration register, pipeline and output.
// Instantiates ect_split, ect_date and ect_clock; depends on ect_pkg.
`timescale 1ns / 1ps

// The block converts one timestamp item per clock cycle into calendar date and time of day
// while rsp_ready stays high. An item accepted on req_ passes through these stages to rsp_:
// three stages split off the day and second of day, seven stages derive the date while the
// time of day runs alongside, and one output register holds the result. The whole pipeline
// advances together, so req_ready is low only while a finished item waits on rsp_ for
// rsp_ready. The zone offset at csr_ address 0 should only be written while no item is in
// flight; it is subtracted from every timestamp before conversion.

module epoch_seconds_to_calendar_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_epoch_seconds,
   input  logic [19:0]                    req_micro_part,
   input  logic                           req_parse_failed,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [11:0]                    rsp_year_out,
   output logic [3:0]                     rsp_month_out,
   output logic [4:0]                     rsp_day_out,
   output logic [4:0]                     rsp_hour_out,
   output logic [5:0]                     rsp_minute_out,
   output logic [5:0]                     rsp_second_out,
   output logic [16:0]                    rsp_fraction_out,
   output logic                           rsp_invalid,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ect_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ect_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ect_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int DEPTH = ect_pkg::DATE_DEPTH;

   typedef struct packed {
      logic        valid;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [16:0] frac;
      logic        invalid;
   } rsp_type;

   logic [ect_pkg::ZONE_W-1:0] zone_ff, zone_in;
   logic                       zone_write;
   logic                       adv;

   ect_pkg::split_type split;
   ect_pkg::date_type  date;
   ect_pkg::clock_type tod;
   ect_pkg::side_type  side_in;
   ect_pkg::side_type  side_ff [DEPTH];
   rsp_type            rsp_ff, rsp_in;

   assign csr_pready = 1'b1;
   assign zone_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[2] == ect_pkg::CSR_IDX_ZONE);
   assign zone_in    = csr_pwdata[ect_pkg::ZONE_W-1:0];

   always_comb begin
      if (csr_paddr[2] == ect_pkg::CSR_IDX_ZONE) begin
         csr_prdata = {{(ect_pkg::CSR_DATA_W - ect_pkg::ZONE_W){1'b0}}, zone_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
      end else if (zone_write) begin
         zone_ff <= zone_in;
      end
   end

   assign adv       = !rsp_ff.valid || rsp_ready;
   assign req_ready = adv;

   ect_split u_split (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .epoch_seconds (req_epoch_seconds),
      .micro_part    (req_micro_part),
      .parse_failed  (req_parse_failed),
      .zone_offset   (zone_ff),
      .split_out     (split)
   );

   ect_date u_date (
      .clock    (clock),
      .adv      (adv),
      .day_id   (split.day_id),
      .date_out (date)
   );

   ect_clock u_clock (
      .clock     (clock),
      .adv       (adv),
      .day_sec   (split.day_sec),
      .clock_out (tod)
   );

   always_comb begin
      side_in.valid = split.valid;
      side_in.ok    = split.ok;
      side_in.frac  = split.frac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      rsp_in.valid   = side_ff[DEPTH-1].valid;
      rsp_in.invalid = !side_ff[DEPTH-1].ok;
      if (side_ff[DEPTH-1].ok) begin
         rsp_in.year   = date.year;
         rsp_in.month  = date.month;
         rsp_in.day    = date.day;
         rsp_in.hour   = tod.hour;
         rsp_in.minute = tod.minute;
         rsp_in.second = tod.second;
         rsp_in.frac   = side_ff[DEPTH-1].frac;
      end else begin
         rsp_in.year   = '0;
         rsp_in.month  = '0;
         rsp_in.day    = '0;
         rsp_in.hour   = '0;
         rsp_in.minute = '0;
         rsp_in.second = '0;
         rsp_in.frac   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_ff.valid;
   assign rsp_year_out     = rsp_ff.year;
   assign rsp_month_out    = rsp_ff.month;
   assign rsp_day_out      = rsp_ff.day;
   assign rsp_hour_out     = rsp_ff.hour;
   assign rsp_minute_out   = rsp_ff.minute;
   assign rsp_second_out   = rsp_ff.second;
   assign rsp_fraction_out = rsp_ff.frac;
   assign rsp_invalid      = rsp_ff.invalid;

endmodule

// File: tb/ect_checker.sv
// Checker for the epoch-to-calendar converter: watches the req_, rsp_ and csr_ ports,
// predicts each calendar result and compares it field by field.
// Depends on ect_pkg for the configuration port widths and register index.
`timescale 1ns / 1ps

module ect_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [31:0]                    req_epoch_seconds,
   input  logic [19:0]                    req_micro_part,
   input  logic                           req_parse_failed,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [11:0]                    rsp_year_out,
   input  logic [3:0]                     rsp_month_out,
   input  logic [4:0]                     rsp_day_out,
   input  logic [4:0]                     rsp_hour_out,
   input  logic [5:0]                     rsp_minute_out,
   input  logic [5:0]                     rsp_second_out,
   input  logic [16:0]                    rsp_fraction_out,
   input  logic                           rsp_invalid,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ect_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ect_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             expected_left,
   output int                             mismatches
);

   localparam longint LAST_SECOND = 64'sd4102444799;
   localparam int unsigned SECONDS_PER_DAY = 86400;
   localparam int unsigned DAYS_FROM_1900 = 25568;
   localparam int unsigned LEAP_CYCLE_DAYS = 1461;
   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned LAST_DAY_INDEX = 364;
   localparam int unsigned FIRST_YEAR = 1900;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [16:0] fraction;
      logic        invalid;
   } calendar_type;

   calendar_type       dates_due[$];
   logic signed [16:0] zone_offset;
   int                 errors = 0;

   function automatic bit is_leap_year(int unsigned y);
      return ((y % 400) == 0 && (y % 4000) != 0) || ((y % 100) != 0 && (y % 4) == 0);
   endfunction

   // Days before the first of month idx (0 = January).
   function automatic int unsigned month_offset(bit leap, int unsigned idx);
      int unsigned days;
      unique case (idx)
         0:       days = 0;
         1:       days = 31;
         2:       days = 59;
         3:       days = 90;
         4:       days = 120;
         5:       days = 151;
         6:       days = 181;
         7:       days = 212;
         8:       days = 243;
         9:       days = 273;
         10:      days = 304;
         default: days = 334;
      endcase
      if (leap && idx >= 2) begin
         days = days + 1;
      end
      return days;
   endfunction

   function automatic calendar_type to_calendar(logic [31:0] secs, logic [19:0] micro,
                                                logic failed, logic signed [16:0] zone);
      calendar_type      r;
      longint            adjusted;
      longint unsigned   ts;
      int unsigned       day_num, cycle_adj, yr, ydays, idx;
      bit                leap;
      r = '0;
      adjusted = longint'({32'd0, secs}) - longint'(zone);
      if (failed || adjusted < 0 || adjusted > LAST_SECOND) begin
         r.invalid = 1'b1;
         return r;
      end
      ts = adjusted;
      day_num = 32'(ts / SECONDS_PER_DAY) + DAYS_FROM_1900;
      r.second = 6'(ts % 60);
      r.minute = 6'((ts / 60) % 60);
      r.hour = 5'((ts / 3600) % 24);
      cycle_adj = day_num - day_num / LEAP_CYCLE_DAYS;
      yr = cycle_adj / DAYS_PER_YEAR;
      ydays = day_num - ((yr - 1) / 4 + yr * DAYS_PER_YEAR);
      // The cycle estimate lands one year late on the last day of some years.
      if ((cycle_adj % DAYS_PER_YEAR) == 0 && (ydays == 0 || ydays > LAST_DAY_INDEX)) begin
         r.year = 12'(FIRST_YEAR + yr - 1);
         r.month = 4'd12;
         r.day = 5'd31;
      end else begin
         r.year = 12'(FIRST_YEAR + yr);
         leap = is_leap_year(FIRST_YEAR + yr);
         idx = 11;
         while (idx > 0 && ydays <= month_offset(leap, idx)) begin
            idx = idx - 1;
         end
         r.day = 5'(ydays - month_offset(leap, idx));
         r.month = 4'(idx + 1);
      end
      r.fraction = 17'(micro / 10);
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      calendar_type want;
      if (reset) begin
         dates_due.delete();
         zone_offset = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (dates_due.size() == 0) begin
               $error("rsp item arrived with no expectation waiting");
               errors++;
            end else begin
               want = dates_due.pop_front();
               check_field("year_out", 32'(want.year), 32'(rsp_year_out));
               check_field("month_out", 32'(want.month), 32'(rsp_month_out));
               check_field("day_out", 32'(want.day), 32'(rsp_day_out));
               check_field("hour_out", 32'(want.hour), 32'(rsp_hour_out));
               check_field("minute_out", 32'(want.minute), 32'(rsp_minute_out));
               check_field("second_out", 32'(want.second), 32'(rsp_second_out));
               check_field("fraction_out", 32'(want.fraction), 32'(rsp_fraction_out));
               check_field("invalid", 32'(want.invalid), 32'(rsp_invalid));
            end
         end
         if (req_valid && req_ready) begin
            dates_due.push_back(to_calendar(req_epoch_seconds, req_micro_part,
                                            req_parse_failed, zone_offset));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             (csr_paddr >> 2) == ect_pkg::CSR_IDX_ZONE) begin
            zone_offset = csr_pwdata[16:0];
         end
      end
      expected_left <= dates_due.size();
      mismatches <= errors;
   end

endmodule

// File: tb/tb_epoch_seconds_to_calendar_top.sv
// Testbench top for epoch_seconds_to_calendar_top: drives timestamps, zone offsets and
// random back-pressure, and reports the verdict from the failure count of ect_checker.
// Depends on ect_pkg, ect_checker and the block under test.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_top;

   localparam logic [ect_pkg::CSR_ADDR_W-1:0] ZONE_ADDR = {ect_pkg::CSR_IDX_ZONE, 2'b00};
   localparam logic [ect_pkg::CSR_ADDR_W-1:0] SPARE_REG_ADDR = 3'd4;
   localparam int LONG_HOLD = 120;
   localparam int PHASE_ITEMS = 242;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_epoch_seconds;
   logic [19:0] req_micro_part;
   logic        req_parse_failed;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;
   logic [16:0] rsp_fraction_out;
   logic        rsp_invalid;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [ect_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [ect_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [ect_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;
   int          expected_left;
   int          mismatches;
   bit          hold_request = 1'b0;
   int          items_sent = 0;
   logic signed [16:0] current_zone = '0;

   epoch_seconds_to_calendar_top uut (.*);
   ect_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("tb_epoch_seconds_to_calendar_top: FAIL");
      $finish;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 19) < 17) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic longint year_start(int y);
      return longint'((y - 1970) * 365 + (y - 1969) / 4) * 86400;
   endfunction

   task automatic send_stamp(input logic [31:0] secs, input logic [19:0] micro,
                             input logic failed);
      int gap;
      bit calm;
      calm = ((items_sent / 100) % 4) == 1;
      gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      req_micro_part <= micro;
      req_parse_failed <= failed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Drains the pipeline, then does one write on the configuration port.
   task automatic write_reg(input logic [ect_pkg::CSR_ADDR_W-1:0] addr, input int value);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ZONE_ADDR) begin
         current_zone = 17'(value);
      end
   endtask

   task automatic send_random_stamp();
      int kind;
      int delta;
      longint target;
      logic [31:0] secs;
      logic [19:0] micro;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         secs = $urandom;
      end else if (kind <= 2) begin
         // Around a new year, reaching back over the last two days of the old one.
         if ($urandom_range(0, 1) == 0) begin
            delta = int'($urandom_range(0, 172803)) - 172800;
         end else begin
            delta = int'($urandom_range(0, 6)) - 3;
         end
         target = year_start($urandom_range(1971, 2100)) + longint'(current_zone) + delta;
         secs = target[31:0];
      end else if (kind == 3) begin
         target = ($urandom_range(0, 1) == 0) ? 64'd0 : 64'd4102444800;
         target = target + longint'(current_zone) + (int'($urandom_range(0, 6)) - 3);
         secs = target[31:0];
      end else begin
         secs = $urandom_range(0, 32'd4102444799);
      end
      if ($urandom_range(0, 9) == 0) begin
         micro = 20'($urandom_range(0, 20'hFFFFF));
      end else begin
         micro = 20'($urandom_range(0, 999999));
      end
      send_stamp(secs, micro, $urandom_range(0, 15) == 0);
   endtask

   initial begin : receiver
      int gap_left;
      int cycles;
      bit hold_done;
      bit calm;
      rsp_ready = 1'b0;
      gap_left = 0;
      cycles = 0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         calm = ((cycles / 256) % 4) == 2;
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            gap_left = LONG_HOLD;
         end
         if (gap_left > 0) begin
            rsp_ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) begin
               gap_left = pick_gap();
            end
         end
         @(posedge clock);
         cycles++;
      end
   end

   initial begin : stimulus
      int zone;
      reset = 1'b1;
      req_valid = 1'b0;
      req_epoch_seconds = '0;
      req_micro_part = '0;
      req_parse_failed = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zone offset at its reset value.
      send_stamp(32'd0, 20'd0, 1'b0);
      send_stamp(32'd4102444799, 20'd999999, 1'b0);
      send_stamp(32'd4102444800, 20'd5, 1'b0);
      send_stamp(32'hFFFFFFFF, 20'hFFFFF, 1'b0);
      send_stamp(32'd951782400, 20'd123456, 1'b1);
      send_stamp(32'd951782400, 20'hFFFFF, 1'b0);
      send_stamp(32'd951868800, 20'd10, 1'b0);
      send_stamp(32'd68169600, 20'd9, 1'b0);
      send_stamp(32'd4007836799, 20'd0, 1'b0);
      send_stamp(32'd946684799, 20'd999990, 1'b0);
      send_stamp(32'd978264000, 20'd524288, 1'b0);
      send_stamp(32'h80000000, 20'd77777, 1'b0);

      write_reg(ZONE_ADDR, 43200);
      send_stamp(32'd43199, 20'd1, 1'b0);
      send_stamp(32'd43200, 20'd2, 1'b0);
      send_stamp(32'd4102487999, 20'd3, 1'b0);
      send_stamp(32'd4102488000, 20'd4, 1'b0);

      write_reg(ZONE_ADDR, -50400);
      send_stamp(32'd0, 20'd11, 1'b0);
      send_stamp(32'd4102394399, 20'd12, 1'b0);
      send_stamp(32'd4102394400, 20'd13, 1'b0);
      send_stamp(32'hFFFFFFFF, 20'd14, 1'b0);

      // A write beyond the only register must leave the zone offset alone.
      write_reg(SPARE_REG_ADDR, 12345);
      send_stamp(32'd4102394400, 20'd15, 1'b0);
      send_stamp(32'd1234567890, 20'd16, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         unique case (phase)
            0:       zone = 43200;
            1:       zone = -50400;
            5:       zone = 0;
            default: zone = int'($urandom_range(0, 93600)) - 50400;
         endcase
         write_reg(ZONE_ADDR, zone);
         if (phase == 0) begin
            hold_request <= 1'b1;
         end
         repeat (PHASE_ITEMS) send_random_stamp();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_epoch_seconds_to_calendar_top: PASS");
      end else begin
         $display("tb_epoch_seconds_to_calendar_top: FAIL");
      end
      $finish;
   end

endmodule
